### src/assert_macros.svh
// Assertion macros for the key matrix scan encoder; included by the controller.
// Each macro is defined empty when SYNTH is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// The property must hold at every rising clock edge outside reset.
`define KMSE_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: check failed");

// The condition must never be true at a rising clock edge outside reset.
`define KMSE_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("%m: forbidden condition seen");

`else

`define KMSE_ASSERT(lbl, clk, rst_n, prop)
`define KMSE_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

### src/kmse_pkg.sv
package kmse_pkg;

  // Matrix geometry defaults.
  localparam int Rows    = 10;
  localparam int Columns = 5;

  // Fixed field widths.
  localparam int ColumnW    = 3;
  localparam int RowLevelsW = 10;
  localparam int KeycodeW   = 9;
  localparam int LayerW     = 2;
  localparam int MapArgW    = 4;
  localparam int MapIdxW    = 8;

  // Keymap geometry and modifier key positions.
  localparam int Layers    = 4;
  localparam int MapRows   = 10;
  localparam int MapCols   = 5;
  localparam int ModRow    = 8;
  localparam int SecondCol = 1;
  localparam int ModeCol   = 0;
  localparam int Unmapped  = -1;

  // One scanned column.
  typedef struct packed {
    logic [ColumnW-1:0]    column;
    logic [RowLevelsW-1:0] row_levels;
  } scan_t;

  // One key event.
  typedef struct packed {
    logic signed [KeycodeW-1:0] keycode;
    logic                       pressed;
    logic                       last;
  } evt_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic in_ready;
    logic emit;
    logic next_row;
    logic next_layer;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic              in_valid;
    logic              col_ok;
    logic              rise;
    logic              fall;
    logic              any_left;
    logic              last;
    logic              out_free;
    logic [LayerW-1:0] layer;
  } status_t;

  // Keymap, flattened as layer * 50 + table row * 5 + column.
  localparam int KeyMap [Layers*MapRows*MapCols] = '{
    // Layer 0
    59, 60, 61, 62, 63,
    -1, -1, 111, 105, 103,
    58, 97, 42, 108, 106,
    30, 48, 46, 56, 14,
    32, 18, 33, 34, 35,
    23, 36, 37, 38, 50,
    49, 24, 25, 16, 19,
    31, 20, 22, 47, 17,
    45, 21, 44, -1, 40,
    -1, 57, 39, -1, 28,
    // Layer 1
    59, 60, 61, 62, 63,
    -1, -1, 111, 105, 103,
    58, 97, 42, 108, 106,
    30, 48, 46, 56, 14,
    32, 18, 33, 34, 35,
    23, 36, 37, 38, 50,
    49, 8, 9, 10, 19,
    31, 5, 6, 7, 12,
    45, 2, 3, 4, 13,
    -1, 11, 39, -1, 28,
    // Layer 2
    59, 60, 61, 62, 63,
    -1, -1, 111, 105, 103,
    58, 97, 42, 108, 106,
    30, 48, 46, 56, 14,
    32, 18, 33, 34, 35,
    23, 36, 37, 38, 50,
    49, 8, 9, 10, 19,
    31, 5, 6, 7, 12,
    45, 2, 3, 4, 13,
    -1, 11, 39, -1, 28,
    // Layer 3
    59, 60, 61, 62, 63,
    -1, -1, 111, 105, 103,
    58, 97, 42, 108, 106,
    30, 48, 46, 56, 14,
    32, 18, 33, 34, 35,
    23, 36, 37, 38, 50,
    49, 8, 9, 10, 19,
    31, 5, 6, 7, 12,
    45, 2, 3, 4, 13,
    -1, 11, 39, -1, 28
  };

  // Look up a keycode; positions outside the keymap are unmapped.
  function automatic logic [KeycodeW-1:0] keycode_lookup(
    input logic [LayerW-1:0]  layer,
    input logic [MapArgW-1:0] trow,
    input logic [MapArgW-1:0] col
  );
    logic [MapIdxW-1:0] idx;
    idx = MapIdxW'(layer) * MapIdxW'(MapRows * MapCols)
        + MapIdxW'(trow) * MapIdxW'(MapCols) + MapIdxW'(col);
    if ((trow < MapArgW'(MapRows)) && (col < MapArgW'(MapCols))) begin
      return KeycodeW'(KeyMap[idx]);
    end
    return KeycodeW'(Unmapped);
  endfunction

endpackage

### src/kmse_chan_if.sv
interface kmse_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### src/kmse_datapath.sv
module kmse_datapath #(
  parameter int ROWS    = kmse_pkg::Rows,
  parameter int COLUMNS = kmse_pkg::Columns
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  kmse_chan_if.sink          scan_i,
  kmse_chan_if.source        evt_o,
  input  kmse_pkg::cmd_t     cmd_i,
  output kmse_pkg::status_t  st_o
);

  localparam int RowW   = $clog2(ROWS);
  localparam int ColW   = $clog2(COLUMNS);
  localparam int WideW  = (ROWS > kmse_pkg::RowLevelsW) ? ROWS : kmse_pkg::RowLevelsW;
  localparam bit HasMod = (kmse_pkg::ModRow < ROWS);

  logic [ROWS-1:0]               levels_q [COLUMNS];
  logic [ROWS-1:0]               old_q;
  logic [ROWS-1:0]               new_q;
  logic [ColW-1:0]               col_q;
  logic [RowW-1:0]               row_q;
  logic [kmse_pkg::LayerW-1:0]   layer_q;
  logic                          out_valid_q;
  kmse_pkg::evt_t                out_q;

  logic [WideW-1:0]              wide_lvl;
  logic [ROWS-1:0]               new_lvl;
  logic [ColW-1:0]               col_in;
  logic                          col_ok;
  logic                          load;
  logic [ROWS-1:0]               edges;
  logic [ROWS-1:0]               pending;
  logic                          rise;
  logic                          fall;
  logic                          later;
  logic                          out_free;
  logic                          mode_bit;
  logic                          second_bit;
  logic [kmse_pkg::LayerW-1:0]   layer_sel;
  logic [kmse_pkg::MapArgW-1:0]  trow;
  logic [kmse_pkg::KeycodeW-1:0] code;
  logic                          last;

  // Modifier keys as seen right after the current row is stored.
  if (HasMod) begin : g_mod
    always_comb begin
      if ((col_q == ColW'(kmse_pkg::ModeCol)) && (32'(row_q) < kmse_pkg::ModRow)) begin
        mode_bit = old_q[kmse_pkg::ModRow];
      end else begin
        mode_bit = levels_q[kmse_pkg::ModeCol][kmse_pkg::ModRow];
      end
      if ((col_q == ColW'(kmse_pkg::SecondCol)) && (32'(row_q) < kmse_pkg::ModRow)) begin
        second_bit = old_q[kmse_pkg::ModRow];
      end else begin
        second_bit = levels_q[kmse_pkg::SecondCol][kmse_pkg::ModRow];
      end
    end
  end else begin : g_no_mod
    assign mode_bit   = 1'b0;
    assign second_bit = 1'b0;
  end

  // Input decode and per-row edge detection.
  always_comb begin
    wide_lvl  = WideW'(scan_i.data.row_levels);
    new_lvl   = wide_lvl[ROWS-1:0];
    col_in    = ColW'(scan_i.data.column);
    col_ok    = (32'(scan_i.data.column) < 32'(COLUMNS));
    load      = scan_i.valid & cmd_i.in_ready & col_ok;
    edges     = old_q ^ new_q;
    pending   = edges >> row_q;
    later     = |(pending >> 1);
    rise      = new_q[row_q] & ~old_q[row_q];
    fall      = ~new_q[row_q] & old_q[row_q];
    out_free  = ~out_valid_q | evt_o.ready;
    layer_sel = rise ? {second_bit, mode_bit} : layer_q;
    trow      = kmse_pkg::MapArgW'(ROWS - 1) - kmse_pkg::MapArgW'(row_q);
    code      = kmse_pkg::keycode_lookup(layer_sel, trow, kmse_pkg::MapArgW'(col_q));
    last      = ~later & (rise | (layer_q == kmse_pkg::LayerW'(kmse_pkg::Layers - 1)));
  end

  // Status toward the controller.
  always_comb begin
    st_o.in_valid = scan_i.valid;
    st_o.col_ok   = col_ok;
    st_o.rise     = rise;
    st_o.fall     = fall;
    st_o.any_left = |pending;
    st_o.last     = last;
    st_o.out_free = out_free;
    st_o.layer    = layer_q;
  end

  // Key level store, row and layer counters, output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < COLUMNS; c++) begin
        levels_q[c] <= '0;
      end
      row_q       <= '0;
      layer_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        levels_q[col_in] <= new_lvl;
        row_q            <= '0;
        layer_q          <= '0;
      end else if (cmd_i.next_row) begin
        row_q   <= row_q + 1'b1;
        layer_q <= '0;
      end else if (cmd_i.next_layer) begin
        layer_q <= layer_q + 1'b1;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (evt_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Column snapshot and output payload.
  always_ff @(posedge clk_i) begin
    if (load) begin
      old_q <= levels_q[col_in];
      new_q <= new_lvl;
      col_q <= col_in;
    end
    if (cmd_i.emit) begin
      out_q.keycode <= code;
      out_q.pressed <= rise;
      out_q.last    <= last;
    end
  end

  assign scan_i.ready = cmd_i.in_ready;
  assign evt_o.valid  = out_valid_q;
  assign evt_o.data   = out_q;

endmodule

### src/kmse_ctrl.sv
`include "assert_macros.svh"

module kmse_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  kmse_pkg::status_t st_i,
  output kmse_pkg::cmd_t    cmd_o
);

  typedef enum logic {
    IDLE,
    SCAN
  } state_e;

  state_e state_q;
  state_e state_d;

  // Next state and commands.
  always_comb begin
    state_d          = state_q;
    cmd_o.in_ready   = 1'b0;
    cmd_o.emit       = 1'b0;
    cmd_o.next_row   = 1'b0;
    cmd_o.next_layer = 1'b0;
    unique case (state_q)
      IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (st_i.in_valid && st_i.col_ok) begin
          state_d = SCAN;
        end
      end
      SCAN: begin
        priority if (!st_i.any_left) begin
          state_d = IDLE;
        end else if (!st_i.rise && !st_i.fall) begin
          cmd_o.next_row = 1'b1;
        end else if (st_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (st_i.last) begin
            state_d = IDLE;
          end else if (st_i.rise ||
                       st_i.layer == kmse_pkg::LayerW'(kmse_pkg::Layers - 1)) begin
            cmd_o.next_row = 1'b1;
          end else begin
            cmd_o.next_layer = 1'b1;
          end
        end
      end
      default: begin
        state_d = IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // The final event of a sample returns the controller to idle.
  `KMSE_ASSERT(a_last_ends_scan, clk_i, rst_ni, (cmd_o.emit && st_i.last) |=> state_q == IDLE)
  // Release layers only advance within a falling row.
  `KMSE_ASSERT(a_layer_on_fall, clk_i, rst_ni, (st_i.layer != '0) |-> st_i.fall)
  // A new sample always starts at layer zero.
  `KMSE_ASSERT(a_idle_layer_zero, clk_i, rst_ni, (state_q == IDLE && st_i.in_valid && st_i.col_ok) |=> (st_i.layer == '0))
  // Never overwrite an event that is still waiting.
  `KMSE_ASSERT_NEVER(a_no_overrun, clk_i, rst_ni, cmd_o.emit && !st_i.out_free)

endmodule

### src/key_matrix_scan_event_encoder_top.sv
// A sample is taken in idle and stored; the controller then walks the rows from row 0 upward,
// stepping over each unchanged row and registering an output event for each changed row.
// A press gives one event and a release four, one per layer. A column out of range is taken
// and ignored. No new sample is taken until the row walk has returned to idle, and a held
// output event stalls the row walk.
// Reset clears the stored key matrix to all released and returns the controller to idle.
module key_matrix_scan_event_encoder_top #(
  parameter int ROWS    = kmse_pkg::Rows,
  parameter int COLUMNS = kmse_pkg::Columns
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  kmse_chan_if.sink   scan_i,
  kmse_chan_if.source evt_o
);

  kmse_pkg::cmd_t    cmd;
  kmse_pkg::status_t status;

  // Sequencing of rows, layers and output events.
  kmse_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .st_i   (status),
    .cmd_o  (cmd)
  );

  // Key matrix store, edge detection and keymap lookup.
  kmse_datapath #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .scan_i (scan_i),
    .evt_o  (evt_o),
    .cmd_i  (cmd),
    .st_o   (status)
  );

endmodule
